// ----- design/cbmt_pkg.sv -----
// Package for the counter bank with maximum tracking.
// Holds the operation codes and the input and result beat structs.
// No dependencies.
package cbmt_pkg;

  localparam logic [1:0] KIND_INC  = 2'd0;
  localparam logic [1:0] KIND_DEC  = 2'd1;
  localparam logic [1:0] KIND_CLR  = 2'd2;
  localparam logic [1:0] KIND_READ = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] index;
  } cbmt_in_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic signed [15:0] max_value;
    logic [6:0]         max_multiplicity;
    logic               saturated;
  } cbmt_out_t;

endpackage

// ----- design/counter_bank_max_tracker.sv -----
// Counter bank with maximum tracking: top level with the counter memory, sequencer and result register.
// Each item is handled as a memory read, then a modify and write back; the result beat is registered.
// Losing the sole maximum holder adds a rescan of all counters through the memory read port.
// After reset a clearing pass zeroes every counter in the memory while in_stall stays high.
// Depends on cbmt_pkg, cbmt_mem and cbmt_ctrl.
module counter_bank_max_tracker import cbmt_pkg::*; #(
  parameter int NUM_COUNTERS = 64,
  parameter int COUNT_BITS   = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  cbmt_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output cbmt_out_t out_data
);

  localparam int AW = $clog2(NUM_COUNTERS);

  logic                  mem_rd_en;
  logic [AW-1:0]         mem_rd_addr;
  logic [COUNT_BITS-1:0] mem_rd_data;
  logic                  mem_wr_en;
  logic [AW-1:0]         mem_wr_addr;
  logic [COUNT_BITS-1:0] mem_wr_data;
  logic                  res_free;
  logic                  res_valid;
  cbmt_out_t             res_data;
  logic                  out_valid_r;
  cbmt_out_t             out_data_r;

  cbmt_mem #(
    .DEPTH (NUM_COUNTERS),
    .WIDTH (COUNT_BITS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  cbmt_ctrl #(
    .NUM_COUNTERS (NUM_COUNTERS),
    .COUNT_BITS   (COUNT_BITS),
    .AW           (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .res_free    (res_free),
    .res_valid   (res_valid),
    .res_data    (res_data)
  );

  assign res_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/cbmt_mem.sv -----
// Synchronous single-read, single-write memory holding the counters.
// Read data is registered and appears in the cycle after the read enable.
// No dependencies.
module cbmt_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/cbmt_ctrl.sv -----
// Sequencer for the counter bank: clearing pass, read-modify-write, maximum tracking and rescan.
// Drives the counter memory ports and hands each result to the output register.
// Depends on cbmt_pkg.
module cbmt_ctrl import cbmt_pkg::*; #(
  parameter int NUM_COUNTERS = 64,
  parameter int COUNT_BITS   = 16,
  parameter int AW           = $clog2(NUM_COUNTERS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  cbmt_in_t              in_data,
  output logic                  mem_rd_en,
  output logic [AW-1:0]         mem_rd_addr,
  input  logic [COUNT_BITS-1:0] mem_rd_data,
  output logic                  mem_wr_en,
  output logic [AW-1:0]         mem_wr_addr,
  output logic [COUNT_BITS-1:0] mem_wr_data,
  input  logic                  res_free,
  output logic                  res_valid,
  output cbmt_out_t             res_data
);

  localparam int HW = $clog2(NUM_COUNTERS + 1);
  localparam logic [AW-1:0] LAST = AW'(NUM_COUNTERS - 1);
  localparam logic signed [COUNT_BITS-1:0] TOP = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] BOT = {1'b1, {(COUNT_BITS-1){1'b0}}};
  localparam logic signed [COUNT_BITS-1:0] ONE = COUNT_BITS'(1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [AW-1:0]                 ptr_r, ptr_nxt;
  logic                          issuing_r, issuing_nxt;
  logic                          scan_vld_r, scan_vld_nxt;
  logic                          scan_last_r, scan_last_nxt;
  logic                          scan_first_r, scan_first_nxt;
  logic signed [COUNT_BITS-1:0]  best_r, best_nxt;
  logic [HW-1:0]                 cnt_r, cnt_nxt;
  logic signed [COUNT_BITS-1:0]  cur_max_r, cur_max_nxt;
  logic [HW-1:0]                 holders_r, holders_nxt;
  logic signed [COUNT_BITS-1:0]  val_r, val_nxt;
  logic                          sat_r, sat_nxt;
  logic                          oor_r;
  logic [1:0]                    kind_r;
  logic [AW-1:0]                 addr_r;

  logic                          accept;
  logic                          in_oor;
  logic [31:0]                   idx_ext;
  logic signed [COUNT_BITS-1:0]  oldv;
  logic signed [COUNT_BITS-1:0]  newv;
  logic                          op_sat;
  logic signed [COUNT_BITS-1:0]  best_upd;
  logic [HW-1:0]                 cnt_upd;
  logic [31:0]                   val_ext;
  logic [31:0]                   max_ext;
  logic [31:0]                   hold_ext;

  assign idx_ext  = 32'(in_data.index);
  assign in_oor   = idx_ext >= 32'(NUM_COUNTERS);
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign oldv     = $signed(mem_rd_data);

  always_comb begin
    newv   = oldv;
    op_sat = 1'b0;
    case (kind_r)
      KIND_INC: begin
        if (oldv >= TOP) begin
          op_sat = 1'b1;
        end else begin
          newv = oldv + ONE;
        end
      end
      KIND_DEC: begin
        if (oldv <= BOT) begin
          op_sat = 1'b1;
        end else begin
          newv = oldv - ONE;
        end
      end
      KIND_CLR: newv = '0;
      KIND_READ: newv = oldv;
      default: newv = oldv;
    endcase
  end

  always_comb begin
    if (scan_first_r || (oldv > best_r)) begin
      best_upd = oldv;
      cnt_upd  = HW'(1);
    end else if (oldv == best_r) begin
      best_upd = best_r;
      cnt_upd  = cnt_r + HW'(1);
    end else begin
      best_upd = best_r;
      cnt_upd  = cnt_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    issuing_nxt    = issuing_r;
    scan_vld_nxt   = 1'b0;
    scan_last_nxt  = 1'b0;
    scan_first_nxt = scan_first_r;
    best_nxt       = best_r;
    cnt_nxt        = cnt_r;
    cur_max_nxt    = cur_max_r;
    holders_nxt    = holders_r;
    val_nxt        = val_r;
    sat_nxt        = sat_r;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = idx_ext[AW-1:0];
    mem_wr_en      = 1'b0;
    mem_wr_addr    = addr_r;
    mem_wr_data    = newv;
    res_valid      = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ptr_r;
        mem_wr_data = '0;
        ptr_nxt     = ptr_r + AW'(1);
        if (ptr_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          mem_rd_en = !in_oor;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        val_nxt = oor_r ? '0 : newv;
        sat_nxt = oor_r ? 1'b0 : op_sat;
        if (!oor_r) begin
          mem_wr_en = 1'b1;
        end
        state_nxt = S_DONE;
        if (!oor_r && (newv > oldv)) begin
          if (newv > cur_max_r) begin
            cur_max_nxt = newv;
            holders_nxt = HW'(1);
          end else if ((newv == cur_max_r) && (oldv != cur_max_r)) begin
            holders_nxt = holders_r + HW'(1);
          end
        end else if (!oor_r && (newv < oldv)) begin
          if ((oldv == cur_max_r) && (newv != cur_max_r)) begin
            if (holders_r > HW'(1)) begin
              holders_nxt = holders_r - HW'(1);
            end else begin
              state_nxt      = S_SCAN;
              ptr_nxt        = '0;
              issuing_nxt    = 1'b1;
              scan_first_nxt = 1'b1;
            end
          end
        end
        if ((state_nxt == S_DONE) && res_free) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        mem_rd_en   = issuing_r;
        mem_rd_addr = ptr_r;
        if (issuing_r) begin
          ptr_nxt       = ptr_r + AW'(1);
          scan_vld_nxt  = 1'b1;
          scan_last_nxt = (ptr_r == LAST);
          if (ptr_r == LAST) begin
            issuing_nxt = 1'b0;
          end
        end
        if (scan_vld_r) begin
          best_nxt       = best_upd;
          cnt_nxt        = cnt_upd;
          scan_first_nxt = 1'b0;
        end
        if (scan_vld_r && scan_last_r) begin
          cur_max_nxt = best_upd;
          holders_nxt = cnt_upd;
          if (res_free) begin
            res_valid = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (res_free) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    val_ext  = 32'(val_nxt);
    max_ext  = 32'(cur_max_nxt);
    hold_ext = 32'(holders_nxt);
    res_data.value            = val_ext[15:0];
    res_data.max_value        = max_ext[15:0];
    res_data.max_multiplicity = hold_ext[6:0];
    res_data.saturated        = sat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      ptr_r        <= '0;
      issuing_r    <= 1'b0;
      scan_vld_r   <= 1'b0;
      scan_last_r  <= 1'b0;
      scan_first_r <= 1'b0;
      cur_max_r    <= '0;
      holders_r    <= HW'(NUM_COUNTERS);
    end else begin
      state_r      <= state_nxt;
      ptr_r        <= ptr_nxt;
      issuing_r    <= issuing_nxt;
      scan_vld_r   <= scan_vld_nxt;
      scan_last_r  <= scan_last_nxt;
      scan_first_r <= scan_first_nxt;
      cur_max_r    <= cur_max_nxt;
      holders_r    <= holders_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    cnt_r  <= cnt_nxt;
    val_r  <= val_nxt;
    sat_r  <= sat_nxt;
    if (accept) begin
      kind_r <= in_data.kind;
      addr_r <= idx_ext[AW-1:0];
      oor_r  <= in_oor;
    end
  end

endmodule

// ----- dv/cbmt_board_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard class for the counter bank with maximum tracking testbench.
// Keeps a shadow copy of the bank, predicts each result beat and checks the beats that come back.
// Depends on cbmt_pkg.
package cbmt_board_pkg;
  import cbmt_pkg::*;

  localparam int BANK_DEPTH = 64;
  localparam logic signed [15:0] COUNT_TOP    = 16'sh7fff;
  localparam logic signed [15:0] COUNT_BOTTOM = 16'sh8000;

  class max_tracker_board;
    logic signed [15:0] shadow_bank [BANK_DEPTH];
    logic signed [15:0] shadow_max;
    int                 shadow_holders;
    cbmt_out_t          expected_readouts [$];
    int                 mismatches;
    int                 readouts_checked;
    int                 saturations_seen;
    int                 rescans_seen;

    function new();
      foreach (shadow_bank[k]) shadow_bank[k] = '0;
      shadow_max = '0;
      shadow_holders = BANK_DEPTH;
      mismatches = 0;
      readouts_checked = 0;
      saturations_seen = 0;
      rescans_seen = 0;
    endfunction

    function int pending();
      return expected_readouts.size();
    endfunction

    function void note_op(cbmt_in_t op);
      logic signed [15:0] old_count;
      logic signed [15:0] new_count;
      cbmt_out_t          readout;
      old_count = shadow_bank[op.index];
      new_count = old_count;
      readout = '0;
      case (op.kind)
        KIND_INC: begin
          if (old_count == COUNT_TOP) readout.saturated = 1'b1;
          else new_count = old_count + 16'sd1;
        end
        KIND_DEC: begin
          if (old_count == COUNT_BOTTOM) readout.saturated = 1'b1;
          else new_count = old_count - 16'sd1;
        end
        KIND_CLR: new_count = '0;
        default: ;
      endcase
      shadow_bank[op.index] = new_count;
      if (new_count > old_count) begin
        if (new_count > shadow_max) begin
          shadow_max = new_count;
          shadow_holders = 1;
        end else if (new_count == shadow_max && old_count != shadow_max) begin
          shadow_holders++;
        end
      end else if (new_count < old_count && old_count == shadow_max) begin
        if (shadow_holders > 1) begin
          shadow_holders--;
        end else begin
          // The sole holder fell, so the maximum has to be found again.
          rescans_seen++;
          shadow_max = shadow_bank[0];
          shadow_holders = 0;
          foreach (shadow_bank[k]) begin
            if (shadow_bank[k] > shadow_max) begin
              shadow_max = shadow_bank[k];
              shadow_holders = 1;
            end else if (shadow_bank[k] == shadow_max) begin
              shadow_holders++;
            end
          end
        end
      end
      if (readout.saturated) saturations_seen++;
      readout.value = new_count;
      readout.max_value = shadow_max;
      readout.max_multiplicity = 7'(shadow_holders);
      expected_readouts.insert(expected_readouts.size(), readout);
    endfunction

    function void check_readout(cbmt_out_t got);
      cbmt_out_t want;
      readouts_checked++;
      if (expected_readouts.size() == 0) begin
        $error("result beat arrived with no expectation pending");
        mismatches++;
        return;
      end
      want = expected_readouts.pop_front();
      if (got.value !== want.value) begin
        $error("value: expected %0d, got %0d", want.value, got.value);
        mismatches++;
      end
      if (got.max_value !== want.max_value) begin
        $error("max_value: expected %0d, got %0d", want.max_value, got.max_value);
        mismatches++;
      end
      if (got.max_multiplicity !== want.max_multiplicity) begin
        $error("max_multiplicity: expected %0d, got %0d",
               want.max_multiplicity, got.max_multiplicity);
        mismatches++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for counter_bank_max_tracker: directed beats and biased random traffic.
// Random gaps on the input and random stalls on the output; results checked by the scoreboard class.
// Depends on cbmt_pkg, cbmt_board_pkg and the design files.
module testbench;
  import cbmt_pkg::*;
  import cbmt_board_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  cbmt_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  cbmt_out_t out_data;

  max_tracker_board board;
  bit quiet = 1'b0;
  int ops_sent = 0;
  int idle_cycles = 0;

  counter_bank_max_tracker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  task automatic send_op(input logic [1:0] kind, input logic [5:0] index);
    cbmt_in_t op;
    int       gap;
    op.kind = kind;
    op.index = index;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= op;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_op(op);
    ops_sent++;
  endtask

  task automatic drain_readouts();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [1:0] pick_kind();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return KIND_INC;
    if (r < 7) return KIND_DEC;
    if (r < 8) return KIND_CLR;
    return KIND_READ;
  endfunction

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      board.check_readout(out_data);
    end
  end

  initial begin
    int hold;
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d cycles without a beat.", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [5:0] hot [4];
    logic [5:0] index;
    board = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Ties, loss of a shared maximum, and loss of the sole maximum.
    send_op(KIND_READ, 6'd0);
    send_op(KIND_READ, 6'd63);
    send_op(KIND_INC, 6'd0);
    send_op(KIND_INC, 6'd63);
    send_op(KIND_DEC, 6'd0);
    send_op(KIND_DEC, 6'd63);
    send_op(KIND_DEC, 6'd42);
    send_op(KIND_CLR, 6'd42);
    send_op(KIND_INC, 6'd21);
    send_op(KIND_INC, 6'd21);
    send_op(KIND_CLR, 6'd21);
    send_op(KIND_INC, 6'd1);
    send_op(KIND_INC, 6'd2);
    send_op(KIND_CLR, 6'd1);
    send_op(KIND_DEC, 6'd2);
    send_op(KIND_READ, 6'd2);
    send_op(KIND_CLR, 6'd63);
    drain_readouts();

    for (int burst = 0; burst < 8; burst++) begin
      quiet = (burst % 4 == 3);
      foreach (hot[k]) hot[k] = 6'($urandom_range(0, 63));
      for (int n = 0; n < 200; n++) begin
        if ($urandom_range(0, 9) == 0) index = 6'($urandom_range(0, 63));
        else index = hot[$urandom_range(0, 3)];
        send_op(pick_kind(), index);
      end
      if (burst == 3) drain_readouts();
    end
    quiet = 1'b0;

    drain_readouts();
    repeat (100) @(posedge clk);
    $display("Sent %0d operations and checked %0d results.", ops_sent, board.readouts_checked);
    $display("Saturated results: %0d, maximum rescans: %0d.",
             board.saturations_seen, board.rescans_seen);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/cbmt_pkg.sv
design/cbmt_mem.sv
design/cbmt_ctrl.sv
design/counter_bank_max_tracker.sv
dv/cbmt_board_pkg.sv
dv/testbench.sv
